### design/ctf_pkg.sv
// Shared types, constants and helper functions for the component transfer block.
`timescale 1ns / 1ps
`default_nettype none

package ctf_pkg;

    // Table capacity and the widths that follow from it.
    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int N_W           = $clog2(TABLE_ENTRIES + 1);
    localparam int P_W           = 8 + N_W;

    // Fixed field widths.
    localparam int CHAN_W      = 8;
    localparam int COUNT_W     = 4;
    localparam int WORDS_W     = 64;
    localparam int Q88_W       = 16;
    localparam int PROD_W      = 25;
    localparam int LIN_W       = 26;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE        = 3'd0,
        REG_TABLE_COUNT = 3'd1,
        REG_TABLE_WORDS = 3'd2,
        REG_SLOPE       = 3'd3,
        REG_INTERCEPT   = 3'd4
    } t_reg_idx;

    // Transfer curve selection.
    typedef enum logic [1:0] {
        MODE_IDENTITY = 2'd0,
        MODE_TABLE    = 2'd1,
        MODE_DISCRETE = 2'd2,
        MODE_LINEAR   = 2'd3
    } t_mode;

    // Decoded configuration seen by the datapath.
    typedef struct packed {
        t_mode              mode;
        logic [N_W-1:0]     n;
        logic [WORDS_W-1:0] words;
        logic [Q88_W-1:0]   slope;
        logic [Q88_W-1:0]   intercept;
    } t_cfg;

    // Request moving from the index stages to the blend stages.
    typedef struct packed {
        logic              valid;
        logic              bad;
        logic              linear;
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] r;
        logic [LIN_W-1:0]  lin;
    } t_s2;

    // Exact floor(v / 255) for v below 65280, where the quotient fits in a byte.
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, v} + {9'b0, v[15:8]} + 17'd1;
        return t[15:8];
    endfunction

    // One byte of the packed table.
    function automatic logic [CHAN_W-1:0] table_byte(input logic [WORDS_W-1:0] w,
                                                     input logic [IDX_W-1:0] k);
        return w[k*CHAN_W +: CHAN_W];
    endfunction

endpackage

`default_nettype wire

### design/ctf_in_if.sv
// Input channel interface: one channel value per request.
`timescale 1ns / 1ps
`default_nettype none

interface ctf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] channel_in;

    modport source (output valid, output channel_in, input ready);
    modport sink   (input valid, input channel_in, output ready);
endinterface

`default_nettype wire

### design/ctf_out_if.sv
// Output channel interface: one transformed value and its error flag per request.
`timescale 1ns / 1ps
`default_nettype none

interface ctf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] channel_out;
    logic       bad_table;

    modport source (output valid, output channel_out, output bad_table, input ready);
    modport sink   (input valid, input channel_out, input bad_table, output ready);
endinterface

`default_nettype wire

### design/ctf_cfg_if.sv
// Configuration write channel interface: register index and write data.
`timescale 1ns / 1ps
`default_nettype none

interface ctf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/ctf_cfg.sv
// Configuration register file with the table count clamped to capacity.
`timescale 1ns / 1ps
`default_nettype none

module ctf_cfg (
    input  wire            i_clk,
    input  wire            i_rst_n,
    ctf_cfg_if.sink        i_cfg,
    output ctf_pkg::t_cfg  o_cfg
);
    import ctf_pkg::*;

    t_mode              r_mode;
    logic [COUNT_W-1:0] r_count;
    logic [WORDS_W-1:0] r_words;
    logic [Q88_W-1:0]   r_slope;
    logic [Q88_W-1:0]   r_intercept;

    // Writes are always taken.
    assign i_cfg.ready = 1'b1;

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDENTITY;
            r_count     <= '0;
            r_words     <= '0;
            r_slope     <= 16'sd256;
            r_intercept <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MODE:        r_mode      <= t_mode'(i_cfg.data[1:0]);
                REG_TABLE_COUNT: r_count     <= i_cfg.data[COUNT_W-1:0];
                REG_TABLE_WORDS: r_words     <= i_cfg.data[WORDS_W-1:0];
                REG_SLOPE:       r_slope     <= i_cfg.data[Q88_W-1:0];
                REG_INTERCEPT:   r_intercept <= i_cfg.data[Q88_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A count above capacity acts as a full table.
    always_comb begin
        o_cfg.mode      = r_mode;
        o_cfg.words     = r_words;
        o_cfg.slope     = r_slope;
        o_cfg.intercept = r_intercept;
        if (r_count > COUNT_W'(TABLE_ENTRIES)) begin
            o_cfg.n = N_W'(TABLE_ENTRIES);
        end else begin
            o_cfg.n = r_count[N_W-1:0];
        end
    end

endmodule

`default_nettype wire

### design/ctf_index.sv
// Stages one and two: scaled position, segment index, remainder and linear sum.
`timescale 1ns / 1ps
`default_nettype none

module ctf_index (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  ctf_pkg::t_cfg  i_cfg,
    ctf_in_if.sink         i_in,
    output ctf_pkg::t_s2   o_s2,
    input  wire            i_s2_ready
);
    import ctf_pkg::*;

    // Stage one registers.
    logic                 r_v1;
    logic [CHAN_W-1:0]    r_x1;
    logic [P_W-1:0]       r_p1;
    logic [PROD_W-1:0]    r_prod1;
    logic                 r_bad1;

    // Stage two register.
    t_s2                  r_s2;

    logic                 n_rdy1;
    logic                 n_rdy2;
    logic [N_W-1:0]       n_mult;
    logic [P_W-1:0]       n_p;
    logic [PROD_W-1:0]    n_prod;
    logic                 n_bad;
    logic [7:0]           n_kq8;
    logic [N_W-1:0]       n_kq;
    logic [N_W-1:0]       n_nm1;
    logic [N_W-1:0]       n_ksel;
    logic [N_W:0]         n_ks1;
    logic [N_W-1:0]       n_k2;
    logic [P_W-1:0]       n_rem;
    logic [LIN_W-1:0]     n_lin;
    t_s2                  n_s2;

    // A stage loads when it is empty or its content moves on.
    assign n_rdy2     = !r_s2.valid || i_s2_ready;
    assign n_rdy1     = !r_v1 || n_rdy2;
    assign i_in.ready = n_rdy1;

    // Stage one: multiply by the segment count and by the slope.
    always_comb begin
        if (i_cfg.mode == MODE_TABLE) begin
            n_mult = i_cfg.n - N_W'(1);
        end else begin
            n_mult = i_cfg.n;
        end
        n_p    = {{N_W{1'b0}}, i_in.channel_in} * {{CHAN_W{1'b0}}, n_mult};
        n_prod = PROD_W'($signed({{(PROD_W-Q88_W){i_cfg.slope[Q88_W-1]}}, i_cfg.slope})
                 * $signed({{(PROD_W-CHAN_W){1'b0}}, i_in.channel_in}));
        n_bad  = ((i_cfg.mode == MODE_TABLE) && (i_cfg.n < N_W'(2)))
              || ((i_cfg.mode == MODE_DISCRETE) && (i_cfg.n == '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (n_rdy1) begin
            r_v1 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_rdy1) begin
            r_x1    <= i_in.channel_in;
            r_p1    <= n_p;
            r_prod1 <= n_prod;
            r_bad1  <= n_bad;
        end
    end

    // Stage two: segment index, remainder, table bytes and linear sum.
    always_comb begin
        n_kq8 = div255({{(16-P_W){1'b0}}, r_p1});
        n_kq  = n_kq8[N_W-1:0];
        n_nm1 = i_cfg.n - N_W'(1);
        if ((i_cfg.mode == MODE_DISCRETE) && (n_kq > n_nm1)) begin
            n_ksel = n_nm1;
        end else begin
            n_ksel = n_kq;
        end
        n_ks1 = {1'b0, n_ksel} + (N_W+1)'(1);
        if (n_ks1 < {1'b0, i_cfg.n}) begin
            n_k2 = n_ks1[N_W-1:0];
        end else begin
            n_k2 = n_nm1;
        end
        n_rem = r_p1 - ({n_kq, 8'b0} - {8'b0, n_kq});
        n_lin = {r_prod1[PROD_W-1], r_prod1}
              + ({{2{i_cfg.intercept[Q88_W-1]}}, i_cfg.intercept, 8'b0}
                 - {{10{i_cfg.intercept[Q88_W-1]}}, i_cfg.intercept});

        n_s2.valid  = r_v1;
        n_s2.bad    = r_bad1;
        n_s2.linear = (i_cfg.mode == MODE_LINEAR);
        n_s2.lin    = n_lin;
        n_s2.a      = r_x1;
        n_s2.b      = r_x1;
        n_s2.r      = '0;
        if (!r_bad1) begin
            unique case (i_cfg.mode)
                MODE_TABLE: begin
                    n_s2.a = table_byte(i_cfg.words, n_ksel[IDX_W-1:0]);
                    n_s2.b = table_byte(i_cfg.words, n_k2[IDX_W-1:0]);
                    n_s2.r = n_rem[CHAN_W-1:0];
                end
                MODE_DISCRETE: begin
                    n_s2.a = table_byte(i_cfg.words, n_ksel[IDX_W-1:0]);
                    n_s2.b = table_byte(i_cfg.words, n_ksel[IDX_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (n_rdy2) begin
            r_s2.valid <= n_s2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_rdy2) begin
            r_s2.bad    <= n_s2.bad;
            r_s2.linear <= n_s2.linear;
            r_s2.a      <= n_s2.a;
            r_s2.b      <= n_s2.b;
            r_s2.r      <= n_s2.r;
            r_s2.lin    <= n_s2.lin;
        end
    end

    assign o_s2 = r_s2;

    // The remainder of a division by 255 never reaches 255.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2.valid |-> (r_s2.r != 8'd255))
        else $error("segment remainder out of range");

endmodule

`default_nettype wire

### design/ctf_blend.sv
// Stages three and four: interpolation blend, linear clamp and output register.
`timescale 1ns / 1ps
`default_nettype none

module ctf_blend (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  ctf_pkg::t_s2   i_s2,
    output logic           o_s2_ready,
    ctf_out_if.source      o_out
);
    import ctf_pkg::*;

    // Stage three registers.
    logic              r_v3;
    logic [15:0]       r_v3_sum;
    logic [CHAN_W-1:0] r_lin3;
    logic              r_linear3;
    logic              r_bad3;

    // Stage four (output) registers.
    logic              r_v4;
    logic [CHAN_W-1:0] r_out4;
    logic              r_bad4;

    logic              n_rdy3;
    logic              n_rdy4;
    logic [15:0]       n_sum;
    logic [CHAN_W-1:0] n_lin;
    logic [CHAN_W-1:0] n_out;

    assign n_rdy4     = !r_v4 || o_out.ready;
    assign n_rdy3     = !r_v3 || n_rdy4;
    assign o_s2_ready = n_rdy3;

    // Stage three: weighted sum of the two bytes and the clamped linear value.
    always_comb begin
        n_sum = ({8'b0, i_s2.a} * {8'b0, 8'd255 - i_s2.r})
              + ({8'b0, i_s2.b} * {8'b0, i_s2.r});
        if (i_s2.lin[LIN_W-1] || (i_s2.lin == '0)) begin
            n_lin = '0;
        end else if (i_s2.lin[LIN_W-2:16] != '0) begin
            n_lin = 8'd255;
        end else begin
            n_lin = i_s2.lin[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (n_rdy3) begin
            r_v3 <= i_s2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_rdy3) begin
            r_v3_sum  <= n_sum;
            r_lin3    <= n_lin;
            r_linear3 <= i_s2.linear;
            r_bad3    <= i_s2.bad;
        end
    end

    // Stage four: divide the blend by 255 and pick the result.
    assign n_out = r_linear3 ? r_lin3 : div255(r_v3_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (n_rdy4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_rdy4) begin
            r_out4 <= n_out;
            r_bad4 <= r_bad3;
        end
    end

    assign o_out.valid       = r_v4;
    assign o_out.channel_out = r_out4;
    assign o_out.bad_table   = r_bad4;

    // A short table passes the value through unblended.
    a_bad_passthru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s2.valid && i_s2.bad) |-> ((i_s2.r == '0) && (i_s2.a == i_s2.b)))
        else $error("short table request is not a pass-through");

    // The blend never exceeds full scale squared.
    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !r_linear3) |-> (r_v3_sum <= 16'd65025))
        else $error("blend sum out of range");

    // A stalled stage three keeps its request.
    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !n_rdy4) |=> r_v3)
        else $error("stage three request lost under stall");

endmodule

`default_nettype wire

### design/component_transfer_function.sv
// Top level of the component transfer block: config registers and four-stage pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Channel     Direction  Payload                       Handshake
// i_in        sink       channel_in[7:0]               valid / ready
// o_out       source     channel_out[7:0], bad_table   valid / ready
// i_cfg       sink       index[2:0], data[63:0]        valid / ready (ready always high)
//
// Each value passes four register stages: scale, segment index, blend and divide
// by 255. Its result is presented from the stage four register, where it waits
// until the output takes it. One value is accepted every cycle while the output is not stalled.
// Each stage loads when it is empty or its content moves on, so a stalled output
// holds its result while earlier stages keep filling.
// Synchronous active-low reset clears the valid bits and loads the register reset values.

module component_transfer_function (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ctf_in_if.sink     i_in,
    ctf_out_if.source  o_out,
    ctf_cfg_if.sink    i_cfg
);
    import ctf_pkg::*;

    t_cfg  w_cfg;
    t_s2   w_s2;
    logic  w_s2_ready;

    ctf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    ctf_index u_index (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_in       (i_in),
        .o_s2       (w_s2),
        .i_s2_ready (w_s2_ready)
    );

    ctf_blend u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s2       (w_s2),
        .o_s2_ready (w_s2_ready),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire
